### hw/rtl/tsem_pkg.sv
// package for the sign-elect merge block: payload structs, fsm states, constants
// no dependencies
package tsem_pkg;

    localparam int unsigned DEF_MODELS     = 4;
    localparam int unsigned DEF_ELEMENTS   = 4096;
    localparam int unsigned DEF_VALUE_BITS = 16;

    localparam int unsigned SUM_BITS  = 28;
    localparam int unsigned DENS_BITS = 17;
    localparam int unsigned CNT_BITS  = 13;
    localparam int unsigned MCNT_BITS = 3;
    localparam int unsigned ONE_Q16   = 65536;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_EMIT  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0] REG_DENSITY = 2'd0;
    localparam logic [1:0] REG_ECOUNT  = 2'd1;
    localparam logic [1:0] REG_MCOUNT  = 2'd2;

    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         model_index;
        logic [11:0]        element_index;
        logic signed [15:0] weight_value;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] merged_value;
        logic [11:0]        out_index;
        logic [1:0]         elected_sign;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    // request from the sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [35:0] dividend;
        logic [4:0]  divisor;
    } div_req_t;

endpackage

### hw/rtl/tsem_div.sv
// restoring divider, one quotient bit per cycle
// depends on tsem_pkg
module tsem_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsem_pkg::div_req_t req,
    output logic              done,
    output logic [35:0]       quotient
);
    import tsem_pkg::*;

    logic [35:0] q_reg, q_next;
    logic [4:0]  r_reg, r_next;
    logic [4:0]  d_reg, d_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [5:0]  trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[35]};
        if (req.start) begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            n_next = 6'd36;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = 5'(trial - {1'b0, d_reg});
                q_next = {q_reg[34:0], 1'b1};
            end else begin
                r_next = trial[4:0];
                q_next = {q_reg[34:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        n_reg <= n_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end

    assign done = busy_reg && (n_reg == 6'd1);
    assign quotient = q_next;

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> req.divisor != '0) else $error("zero divisor");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("divider not busy");
    a_div_nostart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !done |-> !req.start) else $error("divider restarted");
endmodule

### hw/rtl/ties_sign_elect_merge.sv
// top level of the sign-elect merge block: weight memory, magnitude sums, sequencer
// depends on tsem_pkg and tsem_div
//
// usage: words enter on s_ (valid/ready), results leave on m_ (valid/ready).
// mode 0 clears the per-model magnitude sums, mode 1 writes a weight into the
// weight memory and adds its magnitude to that model's sum, both as the word is
// accepted and with no result. mode 2 reads the element of every model below the
// model count from the weight memory, one model at a time in three steps (read,
// compare, accumulate), elects the sign and divides the sum by the count in a
// serial divider. one word is in work at a time; s_ready is low while an emit
// runs or while its result waits in the output register, and rises once the
// result is taken and the sequencer has gone from ST_OUT back to ST_IDLE.
// a stalled m_ready holds the result there.
// reset (aresetn low, synchronous) clears the sums, restores the registers to
// no trim, 4096 elements and all models; the weight memory is not cleared and
// must be written before it is merged.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
module ties_sign_elect_merge #(
    parameter int unsigned MODELS     = tsem_pkg::DEF_MODELS,
    parameter int unsigned ELEMENTS   = tsem_pkg::DEF_ELEMENTS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsem_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsem_pkg::out_word_t m_data
);
    import tsem_pkg::*;

    localparam int unsigned MB = (MODELS > 1) ? $clog2(MODELS) : 1;
    localparam int unsigned EB = $clog2(ELEMENTS);
    localparam int unsigned AB = MB + EB;
    localparam int unsigned MCB = $clog2(MODELS + 1);

    logic [15:0] mem [MODELS*ELEMENTS];
    logic [15:0] rd_reg;
    logic [SUM_BITS-1:0] sums_reg [MODELS];

    logic [DENS_BITS-1:0] dens_reg;
    logic [CNT_BITS-1:0]  ecnt_reg;
    logic [MCNT_BITS-1:0] mcnt_reg;

    state_t st_reg, st_next;
    logic [MB-1:0] idx_reg;
    logic [EB-1:0] elem_reg;
    logic [11:0]   oidx_reg;
    logic [MCB-1:0] cnt_lim;
    logic [20:0] pos_sum_reg, neg_sum_reg;
    logic [4:0]  pos_cnt_reg, neg_cnt_reg;
    logic        neg_sel_reg;
    out_word_t   out_reg;
    logic        ovalid_reg;
    logic        last_model;

    logic [EB-1:0] in_elem;
    logic [AB-1:0] wr_addr, rd_addr;
    logic          accept, do_load;
    logic signed [15:0] v;
    logic [15:0]   mag;
    logic [15:0]   cmp_mag;
    logic [SUM_BITS:0] sum_add;
    logic [16:0]   one_minus_d;
    logic [CNT_BITS-1:0] n_eff;
    logic [44:0]   lhs_reg, rhs_reg;
    logic signed [15:0] v_reg;
    div_req_t      dreq;
    logic          ddone;
    logic [35:0]   dquo;

    assign in_elem = EB'(s_data.element_index);
    assign accept = s_valid && s_ready;
    assign do_load = accept && s_data.mode == MODE_LOAD && 32'(s_data.model_index) < MODELS;
    assign wr_addr = {MB'(s_data.model_index), in_elem};
    assign rd_addr = {idx_reg, elem_reg};

    always_ff @(posedge aclk) begin
        if (do_load) mem[wr_addr] <= s_data.weight_value;
        rd_reg <= mem[rd_addr];
    end

    assign mag = s_data.weight_value[15] ? 16'(-s_data.weight_value) : s_data.weight_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODELS; i++) sums_reg[i] <= '0;
        end else if (accept && s_data.mode == MODE_CLEAR) begin
            for (int i = 0; i < MODELS; i++) sums_reg[i] <= '0;
        end else if (do_load) begin
            sums_reg[MB'(s_data.model_index)] <= (sum_add[SUM_BITS]) ? '1 : sum_add[SUM_BITS-1:0];
        end
    end
    assign sum_add = {1'b0, sums_reg[MB'(s_data.model_index)]} + (SUM_BITS+1)'(mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dens_reg <= 17'(ONE_Q16);
            ecnt_reg <= 13'd4096;
            mcnt_reg <= 3'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DENSITY: dens_reg <= cfg_data;
                REG_ECOUNT:  ecnt_reg <= cfg_data[CNT_BITS-1:0];
                REG_MCOUNT:  mcnt_reg <= cfg_data[MCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign one_minus_d = (dens_reg > 17'(ONE_Q16)) ? 17'd0 : 17'(17'(ONE_Q16) - dens_reg);
    assign n_eff = (ecnt_reg == '0) ? 13'd1 : ecnt_reg;
    assign cnt_lim = (32'(mcnt_reg) > MODELS) ? MCB'(MODELS) : MCB'(mcnt_reg);
    assign last_model = (MCB'(idx_reg) + MCB'(1)) >= cnt_lim;
    assign v = rd_reg;
    assign cmp_mag = v[15] ? 16'($unsigned(-v)) : 16'($unsigned(v));

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (accept && s_data.mode == MODE_EMIT)
                st_next = (cnt_lim == '0) ? ST_DIV : ST_READ;
            ST_READ: st_next = ST_CMP;
            ST_CMP:  st_next = ST_ACC;
            ST_ACC:  st_next = last_model ? ST_DIV : ST_READ;
            ST_DIV:  if (!(pos_cnt_reg != '0 || neg_cnt_reg != '0)) st_next = ST_OUT;
                     else if (ddone) st_next = ST_OUT;
            ST_OUT:  if (!ovalid_reg) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    logic div_started_reg;
    logic pos_win;
    assign pos_win = pos_cnt_reg != '0 && pos_sum_reg >= neg_sum_reg;

    // outputs to the divider
    always_comb begin
        dreq.start = st_reg == ST_DIV && !div_started_reg && (pos_cnt_reg != '0 || neg_cnt_reg != '0);
        dreq.dividend = 36'(pos_win ? pos_sum_reg : neg_sum_reg);
        dreq.divisor = pos_win ? pos_cnt_reg : neg_cnt_reg;
    end

    tsem_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .done(ddone), .quotient(dquo));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            div_started_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (m_valid && m_ready) ovalid_reg <= 1'b0;
            div_started_reg <= st_reg == ST_DIV && st_next == ST_DIV;
            if (st_reg == ST_DIV && st_next == ST_OUT) ovalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            elem_reg <= in_elem;
            oidx_reg <= s_data.element_index;
            idx_reg <= '0;
            pos_sum_reg <= '0;
            neg_sum_reg <= '0;
            pos_cnt_reg <= '0;
            neg_cnt_reg <= '0;
        end
        if (st_reg == ST_CMP) begin
            v_reg <= v;
            lhs_reg <= 45'(29'(cmp_mag) * 29'(n_eff)) << 16;
            rhs_reg <= 45'(sums_reg[idx_reg]) * 45'(one_minus_d);
        end
        if (st_reg == ST_ACC) begin
            if (!(lhs_reg < rhs_reg)) begin
                if (!v_reg[15] && v_reg != 0) begin
                    pos_sum_reg <= pos_sum_reg + 21'(v_reg);
                    pos_cnt_reg <= pos_cnt_reg + 5'd1;
                end else if (v_reg[15]) begin
                    neg_sum_reg <= neg_sum_reg + 21'($unsigned(16'(-v_reg)));
                    neg_cnt_reg <= neg_cnt_reg + 5'd1;
                end
            end
            idx_reg <= idx_reg + MB'(1);
        end
        if (st_reg == ST_DIV && st_next == ST_OUT) begin
            out_reg.out_index <= oidx_reg;
            if (pos_cnt_reg == '0 && neg_cnt_reg == '0) begin
                out_reg.merged_value <= '0;
                out_reg.elected_sign <= SIGN_NONE;
            end else if (pos_win) begin
                out_reg.merged_value <= 16'(dquo);
                out_reg.elected_sign <= SIGN_POS;
            end else begin
                out_reg.merged_value <= 16'(-dquo[15:0]);
                out_reg.elected_sign <= SIGN_NEG;
            end
        end
    end

    assign s_ready = st_reg == ST_IDLE;
    assign m_valid = ovalid_reg;
    assign m_data = out_reg;

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> !s_ready) else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_out_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(st_reg) == ST_DIV) else $error("stray result");
endmodule
